/* hw/rtl/lzwc_pkg.sv */
`default_nettype none

package lzwc_pkg;

    localparam int unsigned DictEntriesDefault = 65536;
    localparam int unsigned FirstFreeCode      = 256;
    localparam int unsigned EpochWidth         = 8;
    localparam int unsigned KeyWidth           = 24;
    localparam int unsigned CodeWidth          = 16;
    localparam int unsigned OutDepth           = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } lzwc_in_t;

    typedef struct packed {
        logic [15:0] code;
        logic        last_code;
    } lzwc_out_t;

    // one hash slot: epoch tag, (prefix, byte) key, code holding that key
    typedef struct packed {
        logic [EpochWidth-1:0] epoch;
        logic [KeyWidth-1:0]   key;
        logic [CodeWidth-1:0]  code;
    } lzwc_slot_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK
    } lzwc_state_t;

endpackage

`default_nettype wire

/* hw/rtl/lzwc_dict_ram.sv */
`default_nettype none

module lzwc_dict_ram #(
    parameter int unsigned AW = 16
) (
    input  wire                           aclk,
    input  wire                           wr_en,
    input  wire  [AW-1:0]                 wr_addr,
    input  wire  lzwc_pkg::lzwc_slot_t    wr_data,
    input  wire  [AW-1:0]                 rd_addr,
    output lzwc_pkg::lzwc_slot_t          rd_data
);
    import lzwc_pkg::*;

    lzwc_slot_t mem [2**AW];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

/* hw/rtl/lzw_compressor_unit.sv */
`default_nettype none

// LZW compressor with fixed 16-bit codes. Takes one byte per input word,
// end_of_message flags the final byte; emits one code word per mismatch and
// a final code flagged last_code, after which the dictionary starts over.
// The dictionary lives in one single-port-read hash table of 2**clog2(
// DICT_ENTRIES) slots with linear probing; each slot carries an epoch tag so
// a new message invalidates the table by bumping the epoch. Bytes are taken
// only in the idle state; a byte that opens a message needs no lookup, any
// other byte is looked up in the look state before the next is taken; that
// state probes one more slot per hash collision (one read port, registered
// read) and waits for room in the two-word result buffer. After reset, and
// after every 255 messages when the epoch wraps, a clearing pass sweeps all
// 2**clog2(DICT_ENTRIES) slots while no byte is accepted. Up to two result
// words are buffered, so input is taken while fewer than two results wait.
module lzw_compressor_unit #(
    parameter int unsigned DICT_ENTRIES = lzwc_pkg::DictEntriesDefault
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    s_valid,
    output logic                   s_ready,
    input  wire  lzwc_pkg::lzwc_in_t  s_data,
    output logic                   m_valid,
    input  wire                    m_ready,
    output lzwc_pkg::lzwc_out_t    m_data
);
    import lzwc_pkg::*;

    localparam int unsigned AW = $clog2(DICT_ENTRIES);
    localparam logic [16:0] CodeLimit = 17'(DICT_ENTRIES);
    localparam logic [16:0] FirstFree = 17'(FirstFreeCode);
    localparam logic [EpochWidth-1:0] EpochMax = '1;
    localparam logic [EpochWidth-1:0] EpochFirst = EpochWidth'(1);

    lzwc_state_t state_reg, state_next;
    logic [EpochWidth-1:0] epoch_reg, epoch_next;
    logic [AW-1:0]   clr_reg, clr_next;
    logic [AW-1:0]   probe_reg, probe_next;
    logic [16:0]     free_reg, free_next;
    logic [15:0]     cur_reg, cur_next;
    logic            have_reg, have_next;
    logic [7:0]      byte_reg, byte_next;
    logic            last_reg, last_next;
    lzwc_out_t       q0_reg, q0_next, q1_reg, q1_next;
    logic [1:0]      cnt_reg, cnt_next;

    logic            wr_en;
    logic [AW-1:0]   wr_addr, rd_addr;
    lzwc_slot_t      wr_data, rd_data;

    logic [1:0]      push_n;
    lzwc_out_t       push_a, push_b;
    logic            pop, accept;
    logic [23:0]     look_key;
    logic            occupied, matched;
    logic [1:0]      need;
    logic [1:0]      room;

    lzwc_dict_ram #(.AW(AW)) u_dict (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    function automatic logic [AW-1:0] slot_hash(input logic [15:0] prefix,
                                               input logic [7:0] b);
        logic [AW-1:0] hi;
        hi = {b, {(AW-8){1'b0}}};
        return prefix[AW-1:0] ^ hi;
    endfunction

    assign pop      = m_valid && m_ready;
    assign accept   = s_valid && s_ready;
    assign look_key = {cur_reg, byte_reg};
    assign occupied = (rd_data.epoch == epoch_reg);
    assign matched  = occupied && (rd_data.key == look_key);
    assign need     = 2'(!matched) + 2'(last_reg);
    assign room     = 2'(OutDepth) - cnt_reg;

    // handshake outputs
    always_comb begin
        s_ready = (state_reg == ST_IDLE) && (cnt_reg != 2'(OutDepth));
        m_valid = (cnt_reg != 2'd0);
        m_data  = q0_reg;
    end

    // next state and datapath
    always_comb begin
        state_next = state_reg;
        epoch_next = epoch_reg;
        clr_next   = clr_reg;
        probe_next = probe_reg;
        free_next  = free_reg;
        cur_next   = cur_reg;
        have_next  = have_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        push_n     = 2'd0;
        push_a     = '0;
        push_b     = '0;
        wr_en      = 1'b0;
        wr_addr    = probe_reg;
        wr_data    = '{epoch: epoch_reg, key: look_key, code: free_reg[15:0]};
        rd_addr    = probe_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_data = '0;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (!have_reg) begin
                        if (s_data.end_of_message) begin
                            // one-byte message: emit it and start over
                            push_n = 2'd1;
                            push_a = '{code: {8'd0, s_data.data_byte}, last_code: 1'b1};
                            free_next = FirstFree;
                            if (epoch_reg == EpochMax) begin
                                epoch_next = EpochFirst;
                                state_next = ST_CLEAR;
                            end else begin
                                epoch_next = epoch_reg + EpochWidth'(1);
                            end
                        end else begin
                            cur_next  = {8'd0, s_data.data_byte};
                            have_next = 1'b1;
                        end
                    end else begin
                        byte_next  = s_data.data_byte;
                        last_next  = s_data.end_of_message;
                        probe_next = slot_hash(cur_reg, s_data.data_byte);
                        rd_addr    = slot_hash(cur_reg, s_data.data_byte);
                        state_next = ST_LOOK;
                    end
                end
            end
            ST_LOOK: begin
                if (occupied && !matched) begin
                    // collision: advance to the next slot
                    probe_next = probe_reg + AW'(1);
                    rd_addr    = probe_reg + AW'(1);
                end else if (need <= room) begin
                    if (matched) begin
                        cur_next = rd_data.code;
                    end else begin
                        push_n   = 2'd1;
                        push_a   = '{code: cur_reg, last_code: 1'b0};
                        cur_next = {8'd0, byte_reg};
                        if (free_reg < CodeLimit) begin
                            wr_en     = 1'b1;
                            free_next = free_reg + 17'd1;
                        end
                    end
                    state_next = ST_IDLE;
                    if (last_reg) begin
                        if (matched) begin
                            push_n = 2'd1;
                            push_a = '{code: rd_data.code, last_code: 1'b1};
                        end else begin
                            push_n = 2'd2;
                            push_b = '{code: {8'd0, byte_reg}, last_code: 1'b1};
                        end
                        have_next = 1'b0;
                        free_next = FirstFree;
                        if (epoch_reg == EpochMax) begin
                            epoch_next = EpochFirst;
                            state_next = ST_CLEAR;
                        end else begin
                            epoch_next = epoch_reg + EpochWidth'(1);
                        end
                    end
                end
                // else hold: rereading the same slot returns the same data
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // result buffer: drop the head on pop, then append pushes
    always_comb begin
        logic [1:0] left;
        lzwc_out_t  e0;
        left = cnt_reg - 2'(pop);
        e0   = pop ? q1_reg : q0_reg;
        q0_next = e0;
        q1_next = q1_reg;
        if (left == 2'd0) begin
            q0_next = push_a;
            q1_next = push_b;
        end else if (left == 2'd1) begin
            q1_next = push_a;
        end
        cnt_next = left + push_n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            epoch_reg <= EpochFirst;
            clr_reg   <= '0;
            free_reg  <= FirstFree;
            cur_reg   <= '0;
            have_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            epoch_reg <= epoch_next;
            clr_reg   <= clr_next;
            free_reg  <= free_next;
            cur_reg   <= cur_next;
            have_reg  <= have_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        probe_reg <= probe_next;
        byte_reg  <= byte_next;
        last_reg  <= last_next;
        q0_reg    <= q0_next;
        q1_reg    <= q1_next;
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 2'(OutDepth))
        else $error("result buffer overfilled");

    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        free_reg >= FirstFree && free_reg <= CodeLimit)
        else $error("next free code out of range");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> state_reg == ST_IDLE)
        else $error("byte accepted outside idle");

    a_epoch_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        epoch_reg != '0)
        else $error("epoch equals cleared tag");

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import lzwc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned PAUSE_AT    = 300;   // hold the sender before this word
    localparam int unsigned DRAIN_WAIT  = 64;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    lzwc_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    lzwc_out_t m_data;

    lzw_compressor_unit u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // byte words waiting to be sent, codes waiting to come out
    lzwc_in_t  byte_q[$];
    lzwc_out_t code_q[$];

    // shadow of the compressor: learned (prefix, byte) keys mapped to codes
    logic [15:0]  dict_code[bit [23:0]];
    int unsigned  next_code = FirstFreeCode;
    logic [15:0]  cur_code = '0;
    bit           have_cur = 1'b0;

    int unsigned  err_cnt = 0;
    int unsigned  sent_cnt = 0;
    int unsigned  done_cnt = 0;
    int unsigned  cyc_cnt = 0;
    int unsigned  gap_left = 0;
    int unsigned  stall_left = 0;
    bit           paused = 1'b0;

    // advance the shadow by one accepted byte, queue the codes it emits
    task automatic compress_byte(input lzwc_in_t w);
        bit [23:0] key;
        lzwc_out_t c;
        if (!have_cur) begin
            cur_code = {8'h00, w.data_byte};
            have_cur = 1'b1;
        end else begin
            key = {cur_code, w.data_byte};
            if (dict_code.exists(key)) begin
                cur_code = dict_code[key];
            end else begin
                c.code = cur_code;
                c.last_code = 1'b0;
                code_q = {code_q, c};
                // full dictionary: emit, learn nothing
                if (next_code < DictEntriesDefault) begin
                    dict_code[key] = next_code[15:0];
                    next_code++;
                end
                cur_code = {8'h00, w.data_byte};
            end
        end
        if (w.end_of_message) begin
            c.code = cur_code;
            c.last_code = 1'b1;
            code_q = {code_q, c};
            dict_code.delete();
            next_code = FirstFreeCode;
            have_cur = 1'b0;
        end
    endtask

    task automatic note_error(input string what, input lzwc_out_t want, input lzwc_out_t got);
        err_cnt++;
        if (err_cnt <= 10)
            $display("%s: expected code %0d last %0b, got code %0d last %0b",
                     what, want.code, want.last_code, got.code, got.last_code);
    endtask

    // stretches of back-to-back traffic every third block of 64 words
    function automatic int unsigned draw_wait();
        if ((sent_cnt / 64) % 3 == 2)
            return 0;
        return $urandom_range(0, 7);
    endfunction

    // driver: one nonblocking write to s_valid per edge
    always @(posedge aclk) begin
        logic nv;
        nv = s_valid;
        if (!aresetn) begin
            nv = 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                compress_byte(s_data);
                done_cnt <= done_cnt + 1;
                nv = 1'b0;
            end
            if (!nv) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                end else if (sent_cnt == PAUSE_AT && !paused) begin
                    // hold until every pending code has drained
                    if (code_q.size() == 0)
                        paused <= 1'b1;
                end else if (byte_q.size() > 0) begin
                    s_data <= byte_q.pop_front();
                    nv = 1'b1;
                    sent_cnt <= sent_cnt + 1;
                    gap_left <= draw_wait();
                end
            end
        end
        s_valid <= nv;
    end

    // monitor: check each accepted code against the oldest expectation
    always @(posedge aclk) begin
        int unsigned w;
        lzwc_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            w = stall_left;
            if (m_valid && m_ready) begin
                if (code_q.size() == 0) begin
                    note_error("unexpected word", '0, m_data);
                end else begin
                    want = code_q.pop_front();
                    if (m_data.code !== want.code || m_data.last_code !== want.last_code)
                        note_error("mismatch", want, m_data);
                end
                w = draw_wait();
            end
            if (w > 0) begin
                m_ready <= 1'b0;
                stall_left <= w - 1;
            end else begin
                m_ready <= 1'b1;
                stall_left <= 0;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt > CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic add_message(input int unsigned len, input bit narrow);
        lzwc_in_t w;
        logic [7:0] base;
        base = $urandom_range(0, 255);
        for (int unsigned i = 0; i < len; i++) begin
            // narrow alphabet repeats pairs so the dictionary gets hits
            w.data_byte = narrow ? base + 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
            w.end_of_message = (i == len - 1);
            byte_q = {byte_q, w};
        end
    endtask

    task automatic add_bytes(input logic [7:0] b[$]);
        lzwc_in_t w;
        foreach (b[i]) begin
            w.data_byte = b[i];
            w.end_of_message = (i == b.size() - 1);
            byte_q = {byte_q, w};
        end
    endtask

    initial begin
        int unsigned len;
        int unsigned total;
        // one-byte messages at both extremes
        add_bytes('{8'h00});
        add_bytes('{8'hFF});
        // repeating pair: learned strings get matched and extended
        add_bytes('{8'h41, 8'h42, 8'h41, 8'h42, 8'h41, 8'h42, 8'h41});
        add_bytes('{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00});
        add_bytes('{8'h61, 8'h61, 8'h61, 8'h61, 8'h61, 8'h61});
        while (byte_q.size() < 540) begin
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 24);
            add_message(len, $urandom_range(0, 3) != 0);
        end
        total = byte_q.size();

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        wait (done_cnt == total && code_q.size() == 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (err_cnt == 0 && code_q.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
